FILE: src/base64url_stream_encoder_assert.svh
// Assertion macros shared by the base64url stream encoder modules.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef BASE64URL_STREAM_ENCODER_ASSERT_SVH
`define BASE64URL_STREAM_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64U_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64u assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64U_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64u assertion failed");

`endif

FILE: src/b64u_pkg.sv
// Package for the base64url stream encoder: group command type, queue sizing,
// step codes and the URL-safe alphabet lookup. No dependencies.
package b64u_pkg;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [6:0] CLOSING_CHAR = 7'h2F;

	// Back-end step codes: four characters, then the closing slash.
	localparam logic [2:0] STEP_C0    = 3'd0;
	localparam logic [2:0] STEP_C1    = 3'd1;
	localparam logic [2:0] STEP_C2    = 3'd2;
	localparam logic [2:0] STEP_C3    = 3'd3;
	localparam logic [2:0] STEP_SLASH = 3'd4;

	typedef struct packed {
		logic [23:0] group;
		logic        fin;
	} group_cmd_t;

	function automatic logic [6:0] b64u_char(input logic [5:0] idx);
		logic [6:0] ch;
		if (idx < 6'd26) begin
			ch = 7'h41 + {1'b0, idx};
		end else if (idx < 6'd52) begin
			ch = 7'h61 + {1'b0, idx - 6'd26};
		end else if (idx < 6'd62) begin
			ch = 7'h30 + {1'b0, idx - 6'd52};
		end else if (idx == 6'd62) begin
			ch = 7'h2D;
		end else begin
			ch = 7'h5F;
		end
		return ch;
	endfunction

endpackage

FILE: src/b64u_front.sv
// Front end of the base64url encoder: accepts bytes, gathers groups of three
// and pushes group commands into the queue. Uses b64u_pkg.
module b64u_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // data_byte
	input  logic                 s_tlast,  // is_final
	input  logic                 q_full,
	output logic                 push,
	output b64u_pkg::group_cmd_t push_cmd
);

	logic [15:0] pending_q;
	logic [1:0]  count_q;
	logic        accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && (s_tlast || count_q >= 2'd2);

	always_comb begin
		case (count_q)
			2'd0:    push_cmd.group = {s_tdata, 16'h0000};
			2'd1:    push_cmd.group = {pending_q[15:8], s_tdata, 8'h00};
			default: push_cmd.group = {pending_q, s_tdata};
		endcase
		push_cmd.fin = s_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 16'h0000;
			count_q   <= 2'd0;
		end else if (accept) begin
			if (push) begin
				pending_q <= 16'h0000;
				count_q   <= 2'd0;
			end else if (count_q == 2'd0) begin
				pending_q <= {s_tdata, 8'h00};
				count_q   <= 2'd1;
			end else begin
				pending_q[7:0] <= s_tdata;
				count_q        <= 2'd2;
			end
		end
	end

endmodule

FILE: src/b64u_queue.sv
// Short queue of group commands between front and back end.
// Uses b64u_pkg and the assertion macro header.
`include "base64url_stream_encoder_assert.svh"
module b64u_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  b64u_pkg::group_cmd_t push_cmd,
	input  logic                 pop,
	output b64u_pkg::group_cmd_t head,
	output logic                 full,
	output logic                 empty
);

	b64u_pkg::group_cmd_t        mem_q [b64u_pkg::QDEPTH];
	logic [b64u_pkg::QAW-1:0]    wr_ptr_q;
	logic [b64u_pkg::QAW-1:0]    rd_ptr_q;
	logic [b64u_pkg::QCW-1:0]    count_q;

	assign full  = (count_q == b64u_pkg::QCW'(b64u_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [b64u_pkg::QAW-1:0] next_ptr(input logic [b64u_pkg::QAW-1:0] p);
		return (p == b64u_pkg::QAW'(b64u_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + b64u_pkg::QCW'(1);
				2'b01:   count_q <= count_q - b64u_pkg::QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`B64U_ASSERT_IMP(a_no_overflow, full, !push)
	`B64U_ASSERT_IMP(a_no_underflow, pop, !empty)
	`B64U_ASSERT_IMP(a_count_bound, 1'b1, count_q <= b64u_pkg::QCW'(b64u_pkg::QDEPTH))

endmodule

FILE: src/b64u_back.sv
// Back end of the base64url encoder: walks each group command one character per
// unstalled cycle into the output register. Uses b64u_pkg and the assertion header.
`include "base64url_stream_encoder_assert.svh"
module b64u_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b64u_pkg::group_cmd_t head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,  // character, bit 7 zero
	output logic                 m_tlast,  // last_of_run
	output logic                 m_tuser   // end_of_message
);

	logic [2:0] step_q;
	logic       load;
	logic       last_step;
	logic [5:0] idx;
	logic [6:0] ch;
	logic       ch_last;
	logic       ch_eom;

	assign load      = !m_tvalid || m_tready;
	assign last_step = head.fin ? (step_q == b64u_pkg::STEP_SLASH)
	                            : (step_q == b64u_pkg::STEP_C3);
	assign pop       = load && !empty && last_step;

	always_comb begin
		idx     = head.group[5:0];
		ch_last = 1'b0;
		ch_eom  = 1'b0;
		case (step_q)
			b64u_pkg::STEP_C0: idx = head.group[23:18];
			b64u_pkg::STEP_C1: idx = head.group[17:12];
			b64u_pkg::STEP_C2: idx = head.group[11:6];
			b64u_pkg::STEP_C3: begin
				idx     = head.group[5:0];
				ch_last = !head.fin;
			end
			default: begin
				ch_last = 1'b1;
				ch_eom  = 1'b1;
			end
		endcase
		ch = (step_q == b64u_pkg::STEP_SLASH) ? b64u_pkg::CLOSING_CHAR : b64u_pkg::b64u_char(idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			step_q   <= b64u_pkg::STEP_C0;
		end else if (load) begin
			m_tvalid <= !empty;
			if (!empty) begin
				step_q <= last_step ? b64u_pkg::STEP_C0 : step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			m_tdata <= {1'b0, ch};
			m_tlast <= ch_last;
			m_tuser <= ch_eom;
		end
	end

	`B64U_ASSERT_IMP(a_slash_only_final, step_q == b64u_pkg::STEP_SLASH, !empty && head.fin)
	`B64U_ASSERT_IMP(a_mid_group_has_cmd, step_q != b64u_pkg::STEP_C0, !empty)
	`B64U_ASSERT_IMP(a_eom_is_last, m_tvalid && m_tuser, m_tlast)

endmodule

FILE: src/base64url_stream_encoder.sv
// Top level of the base64url stream encoder (no padding, closing slash).
// Instantiates b64u_front, b64u_queue and b64u_back; uses b64u_pkg.
//
// Usage:
//   Input stream s_*: one message byte per request in s_tdata, s_tlast set on
//   the final byte of a message. Output stream m_*: one character per request,
//   ASCII in m_tdata[6:0], m_tlast on the last character caused by an input
//   byte, m_tuser on the closing '/' that ends a message.
//   Every third byte yields four characters; a final byte yields four
//   characters of its zero-filled group and then '/'. Other bytes yield none.
// Path: the group that a byte completes enters the queue on the edge that accepts
//   that byte; once the groups ahead of it are sent and m_tready frees the output
//   register, the next load puts its first character into the output register.
// Throughput: the back end sends one character per cycle unless m_tready stalls
//   it or the queue is empty; a message of n bytes yields 4*ceil(n/3)+1
//   characters, and the output register sets the sustained pace.
// Reset: arst_n clears the pending byte count, the queue and the output valid.
// Stall: while m_tready is low, the output register holds; the front keeps
//   taking bytes until the two-entry group queue fills, then drops s_tready.
module base64url_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // is_final
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] character, [7] zero
	output logic       m_tlast,   // last_of_run
	output logic       m_tuser    // end_of_message
);

	b64u_pkg::group_cmd_t push_cmd;
	b64u_pkg::group_cmd_t head;
	logic                 push;
	logic                 pop;
	logic                 q_full;
	logic                 q_empty;

	// Gather bytes into groups; push a command per complete or final group.
	b64u_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Decouple byte intake from character output.
	b64u_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Serialize each group into characters, one per cycle unless m_tready stalls.
	b64u_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
